@@ rtl/rwsp_pkg.sv @@
package rwsp_pkg;

  // Parser phases, one per kind of byte the stream can be in.
  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_CHUNKHDR = 3'd1,
    PH_FMT      = 3'd2,
    PH_SKIPFMT  = 3'd3,
    PH_DATA     = 3'd4,
    PH_SKIP     = 3'd5,
    PH_PAD      = 3'd6,
    PH_ERROR    = 3'd7
  } phase_t;

  // Report status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HDR   = 3'd1;
  localparam logic [2:0] ST_FMT_SMALL = 3'd2;
  localparam logic [2:0] ST_FMT_TRUNC = 3'd3;
  localparam logic [2:0] ST_DATA_TRUNC = 3'd4;
  localparam logic [2:0] ST_NO_FMT    = 3'd5;
  localparam logic [2:0] ST_NO_SAMPLES = 3'd6;

  // Result kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Chunk tags as read most significant byte first, and fmt body size.
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_MIN  = 32'd16;
  localparam logic [3:0]  FMT_LAST = 4'd15;
  localparam logic [3:0]  HDR_LAST = 4'd11;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  sample_byte;
    logic        chunk_start;
    logic [15:0] channel_count;
    logic [31:0] sample_rate_hz;
    logic [15:0] sample_bits;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // Expected header byte at a position; the size bytes 4..7 are not checked.
  function automatic logic [7:0] header_magic(input logic [3:0] idx);
    logic [7:0] m;
    unique case (idx)
      4'd0:    m = 8'h52;
      4'd1:    m = 8'h49;
      4'd2:    m = 8'h46;
      4'd3:    m = 8'h46;
      4'd8:    m = 8'h57;
      4'd9:    m = 8'h41;
      4'd10:   m = 8'h56;
      4'd11:   m = 8'h45;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/riff_wave_stream_parser_unit.sv @@
// A result item is written to the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle unless in_stall; a data chunk byte that is also the final
// file byte gives two items; the four-entry queue drains one per cycle unless out_stall.
// Input stall rises while the queue holds three or more items.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to the header phase.
module riff_wave_stream_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_sample_byte,
  output logic        out_chunk_start,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_sample_rate_hz,
  output logic [15:0] out_sample_bits,
  output logic [2:0]  out_status,
  output logic        out_last
);
  import rwsp_pkg::*;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic [3:0]  field_count_r, field_count_nxt;
  logic [31:0] chunk_tag_r, chunk_tag_nxt;
  logic [31:0] chunk_length_r, chunk_length_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic        pad_pending_r, pad_pending_nxt;
  logic        format_seen_r, format_seen_nxt;
  logic        samples_present_r, samples_present_nxt;
  logic [2:0]  error_code_r, error_code_nxt;
  logic [15:0] held_channels_r, held_channels_nxt;
  logic [31:0] held_rate_r, held_rate_nxt;
  logic [15:0] held_bits_r, held_bits_nxt;

  // Result queue.
  result_t     queue_r [4];
  logic [1:0]  head_r, head_nxt;
  logic [1:0]  tail_r, tail_nxt;
  logic [2:0]  count_r, count_nxt;

  logic        accept;
  logic        pop;
  logic        emit_sample;
  logic        emit_report;
  result_t     sample_item;
  result_t     report_item;
  logic [2:0]  status_val;
  logic [1:0]  tail_plus1;

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;
  assign in_stall = (count_r >= 3'd3);
  assign tail_plus1 = tail_r + 2'd1;

  // Per-byte parser step, then the end-of-file report and restart.
  always_comb begin
    phase_nxt           = phase_r;
    field_count_nxt     = field_count_r;
    chunk_tag_nxt       = chunk_tag_r;
    chunk_length_nxt    = chunk_length_r;
    bytes_left_nxt      = bytes_left_r;
    pad_pending_nxt     = pad_pending_r;
    format_seen_nxt     = format_seen_r;
    samples_present_nxt = samples_present_r;
    error_code_nxt      = error_code_r;
    held_channels_nxt   = held_channels_r;
    held_rate_nxt       = held_rate_r;
    held_bits_nxt       = held_bits_r;
    emit_sample         = 1'b0;
    emit_report         = 1'b0;
    status_val          = ST_OK;
    sample_item         = '0;
    report_item         = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if ((field_count_r < 4'd4 || field_count_r >= 4'd8)
            && in_byte_value != header_magic(field_count_r)) begin
          error_code_nxt = ST_BAD_HDR;
          phase_nxt      = PH_ERROR;
        end else if (field_count_r >= HDR_LAST) begin
          field_count_nxt = '0;
          phase_nxt       = PH_CHUNKHDR;
        end else begin
          field_count_nxt = field_count_r + 4'd1;
        end
      end
      PH_CHUNKHDR: begin
        // Tag bytes shift in from the right, length bytes from the left.
        if (field_count_r[2:0] < 3'd4) begin
          chunk_tag_nxt = {chunk_tag_r[23:0], in_byte_value};
        end else begin
          chunk_length_nxt = {in_byte_value, chunk_length_r[31:8]};
        end
        if (field_count_r[2:0] < 3'd7) begin
          field_count_nxt = {1'b0, field_count_r[2:0] + 3'd1};
        end else begin
          field_count_nxt = '0;
          if (chunk_tag_nxt == TAG_FMT) begin
            if (chunk_length_nxt < FMT_MIN) begin
              error_code_nxt = ST_FMT_SMALL;
              phase_nxt      = PH_ERROR;
            end else begin
              phase_nxt = PH_FMT;
            end
          end else begin
            if (chunk_tag_nxt == TAG_DATA) begin
              samples_present_nxt = (chunk_length_nxt != '0);
            end
            bytes_left_nxt = chunk_length_nxt;
            if (chunk_length_nxt == '0) begin
              pad_pending_nxt = 1'b0;
              phase_nxt       = PH_CHUNKHDR;
            end else if (chunk_tag_nxt == TAG_DATA) begin
              phase_nxt = PH_DATA;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
      end
      PH_FMT: begin
        // Pick the format fields out of the first sixteen body bytes.
        unique case (field_count_r)
          4'd2:  held_channels_nxt[7:0]  = in_byte_value;
          4'd3:  held_channels_nxt[15:8] = in_byte_value;
          4'd4:  held_rate_nxt[7:0]      = in_byte_value;
          4'd5:  held_rate_nxt[15:8]     = in_byte_value;
          4'd6:  held_rate_nxt[23:16]    = in_byte_value;
          4'd7:  held_rate_nxt[31:24]    = in_byte_value;
          4'd14: held_bits_nxt[7:0]      = in_byte_value;
          4'd15: held_bits_nxt[15:8]     = in_byte_value;
          default: ;
        endcase
        if (field_count_r < FMT_LAST) begin
          field_count_nxt = field_count_r + 4'd1;
        end else begin
          format_seen_nxt = 1'b1;
          field_count_nxt = '0;
          if (chunk_length_r > FMT_MIN) begin
            bytes_left_nxt = chunk_length_r - FMT_MIN;
            phase_nxt      = PH_SKIPFMT;
          end else begin
            pad_pending_nxt = chunk_length_r[0];
            phase_nxt       = chunk_length_r[0] ? PH_PAD : PH_CHUNKHDR;
          end
        end
      end
      PH_DATA, PH_SKIPFMT, PH_SKIP: begin
        if (phase_r == PH_DATA) begin
          emit_sample             = 1'b1;
          sample_item.kind        = KIND_SAMPLE;
          sample_item.sample_byte = in_byte_value;
          sample_item.chunk_start = (bytes_left_r == chunk_length_r);
        end
        if (bytes_left_r <= 32'd1) begin
          bytes_left_nxt  = '0;
          field_count_nxt = '0;
          pad_pending_nxt = chunk_length_r[0];
          phase_nxt       = chunk_length_r[0] ? PH_PAD : PH_CHUNKHDR;
        end else begin
          bytes_left_nxt = bytes_left_r - 32'd1;
        end
      end
      PH_PAD: begin
        pad_pending_nxt = 1'b0;
        phase_nxt       = PH_CHUNKHDR;
        field_count_nxt = '0;
      end
      PH_ERROR: ;
      default: ;
    endcase

    // Final byte: settle the status, build the report and start over.
    if (in_end_of_file) begin
      emit_report = 1'b1;
      if (phase_nxt == PH_HEADER) begin
        error_code_nxt = ST_BAD_HDR;
      end else if (phase_nxt == PH_FMT) begin
        error_code_nxt = ST_FMT_TRUNC;
      end else if (phase_nxt == PH_DATA) begin
        error_code_nxt = ST_DATA_TRUNC;
      end
      priority if (error_code_nxt != ST_OK) begin
        status_val = error_code_nxt;
      end else if (!format_seen_nxt) begin
        status_val = ST_NO_FMT;
      end else if (!samples_present_nxt) begin
        status_val = ST_NO_SAMPLES;
      end else begin
        status_val = ST_OK;
      end
      report_item.kind   = KIND_REPORT;
      report_item.status = status_val;
      report_item.last   = 1'b1;
      if (status_val == ST_OK) begin
        report_item.channel_count  = held_channels_nxt;
        report_item.sample_rate_hz = held_rate_nxt;
        report_item.sample_bits    = held_bits_nxt;
      end
      phase_nxt           = PH_HEADER;
      field_count_nxt     = '0;
      chunk_tag_nxt       = '0;
      chunk_length_nxt    = '0;
      bytes_left_nxt      = '0;
      pad_pending_nxt     = 1'b0;
      format_seen_nxt     = 1'b0;
      samples_present_nxt = 1'b0;
      error_code_nxt      = ST_OK;
      held_channels_nxt   = '0;
      held_rate_nxt       = '0;
      held_bits_nxt       = '0;
    end
  end

  // Queue pointer and fill count updates.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop) begin
      head_nxt = head_r + 2'd1;
    end
    if (accept) begin
      tail_nxt = tail_r + {1'b0, emit_sample} + {1'b0, emit_report};
    end
    count_nxt = count_r
              + ((accept && emit_sample) ? 3'd1 : 3'd0)
              + ((accept && emit_report) ? 3'd1 : 3'd0)
              - (pop ? 3'd1 : 3'd0);
  end

  // Control and parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_HEADER;
      field_count_r     <= '0;
      chunk_tag_r       <= '0;
      chunk_length_r    <= '0;
      bytes_left_r      <= '0;
      pad_pending_r     <= 1'b0;
      format_seen_r     <= 1'b0;
      samples_present_r <= 1'b0;
      error_code_r      <= ST_OK;
      held_channels_r   <= '0;
      held_rate_r       <= '0;
      held_bits_r       <= '0;
      head_r            <= '0;
      tail_r            <= '0;
      count_r           <= '0;
    end else begin
      if (accept) begin
        phase_r           <= phase_nxt;
        field_count_r     <= field_count_nxt;
        chunk_tag_r       <= chunk_tag_nxt;
        chunk_length_r    <= chunk_length_nxt;
        bytes_left_r      <= bytes_left_nxt;
        pad_pending_r     <= pad_pending_nxt;
        format_seen_r     <= format_seen_nxt;
        samples_present_r <= samples_present_nxt;
        error_code_r      <= error_code_nxt;
        held_channels_r   <= held_channels_nxt;
        held_rate_r       <= held_rate_nxt;
        held_bits_r       <= held_bits_nxt;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Result queue storage: a sample item goes first, a report after it.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (emit_sample) begin
        queue_r[tail_r] <= sample_item;
        if (emit_report) begin
          queue_r[tail_plus1] <= report_item;
        end
      end else if (emit_report) begin
        queue_r[tail_r] <= report_item;
      end
    end
  end

  // Output side reads the queue head.
  assign out_valid          = (count_r != '0);
  assign out_kind           = queue_r[head_r].kind;
  assign out_sample_byte    = queue_r[head_r].sample_byte;
  assign out_chunk_start    = queue_r[head_r].chunk_start;
  assign out_channel_count  = queue_r[head_r].channel_count;
  assign out_sample_rate_hz = queue_r[head_r].sample_rate_hz;
  assign out_sample_bits    = queue_r[head_r].sample_bits;
  assign out_status         = queue_r[head_r].status;
  assign out_last           = queue_r[head_r].last;

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import rwsp_pkg::*;

  // One input item waiting to be offered, with a flag that holds it back until
  // every expected result has come out.
  typedef struct {
    logic [7:0] b;
    logic       eof;
    bit         drain;
  } file_byte_t;

  localparam int          TARGET_BYTES  = 1600;
  localparam logic [31:0] RIFF_ID       = "RIFF";
  localparam logic [31:0] WAVE_ID       = "WAVE";
  localparam logic [31:0] TAG_LIST      = "LIST";
  localparam logic [95:0] HEAD_PATTERN  = {RIFF_ID, 32'h0, WAVE_ID};
  localparam int          HOLDOFF_CYCLES = 80;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_sample_byte;
  logic        out_chunk_start;
  logic [15:0] out_channel_count;
  logic [31:0] out_sample_rate_hz;
  logic [15:0] out_sample_bits;
  logic [2:0]  out_status;
  logic        out_last;

  file_byte_t  file_bytes_q[$];
  logic [7:0]  build_q[$];
  result_t     pending_results[$];

  int          bytes_sent = 0;
  int          taken_seen = 0;
  int          results_seen = 0;
  int          mismatch_count = 0;
  int          hold_left = 0;
  int          holdoffs_done = 0;

  // Parser state kept by the predictor.
  phase_t      ps;
  logic [3:0]  pos;
  logic [31:0] tag_acc;
  logic [31:0] len_acc;
  logic [31:0] remain;
  logic        pad_flag;
  logic        fmt_seen;
  logic        have_samples;
  logic [2:0]  err_code;
  logic [15:0] ch_hold;
  logic [31:0] rate_hold;
  logic [15:0] bits_hold;

  riff_wave_stream_parser_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_value     (in_byte_value),
    .in_end_of_file    (in_end_of_file),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_sample_byte   (out_sample_byte),
    .out_chunk_start   (out_chunk_start),
    .out_channel_count (out_channel_count),
    .out_sample_rate_hz(out_sample_rate_hz),
    .out_sample_bits   (out_sample_bits),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor of the parser.
  // ---------------------------------------------------------------------------

  task automatic clear_parser();
    ps           = PH_HEADER;
    pos          = '0;
    tag_acc      = '0;
    len_acc      = '0;
    remain       = '0;
    pad_flag     = 1'b0;
    fmt_seen     = 1'b0;
    have_samples = 1'b0;
    err_code     = ST_OK;
    ch_hold      = '0;
    rate_hold    = '0;
    bits_hold    = '0;
  endtask

  task automatic set_error(input logic [2:0] code);
    err_code = code;
    ps       = PH_ERROR;
  endtask

  // A chunk body is done; an odd length leaves one pad byte to skip.
  task automatic close_chunk();
    pos      = '0;
    pad_flag = len_acc[0];
    ps       = pad_flag ? PH_PAD : PH_CHUNKHDR;
  endtask

  // Count down a chunk body that is streamed or skipped.
  task automatic count_body();
    if (remain <= 1) begin
      remain = '0;
      close_chunk();
    end else begin
      remain = remain - 1;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    result_t    r;
    logic [2:0] st;
    case (ps)
      PH_HEADER: begin
        if ((pos < 4 || pos >= 8) && b != HEAD_PATTERN[95 - 8*pos -: 8]) begin
          set_error(ST_BAD_HDR);
        end else if (pos >= 11) begin
          pos = '0;
          ps  = PH_CHUNKHDR;
        end else begin
          pos = pos + 4'd1;
        end
      end
      PH_CHUNKHDR: begin
        // Tag arrives most significant byte first, length little-endian.
        if (pos[2:0] < 4) tag_acc = {tag_acc[23:0], b};
        else              len_acc = {b, len_acc[31:8]};
        if (pos[2:0] < 7) begin
          pos = {1'b0, pos[2:0]} + 4'd1;
        end else begin
          pos = '0;
          if (tag_acc == TAG_FMT) begin
            if (len_acc < FMT_MIN) set_error(ST_FMT_SMALL);
            else                   ps = PH_FMT;
          end else begin
            if (tag_acc == TAG_DATA) have_samples = (len_acc != 0);
            remain = len_acc;
            if (len_acc == 0)              close_chunk();
            else if (tag_acc == TAG_DATA)  ps = PH_DATA;
            else                           ps = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        case (pos)
          4'd2:  ch_hold[7:0]     = b;
          4'd3:  ch_hold[15:8]    = b;
          4'd4:  rate_hold[7:0]   = b;
          4'd5:  rate_hold[15:8]  = b;
          4'd6:  rate_hold[23:16] = b;
          4'd7:  rate_hold[31:24] = b;
          4'd14: bits_hold[7:0]   = b;
          4'd15: bits_hold[15:8]  = b;
          default: ;
        endcase
        if (pos < 15) begin
          pos = pos + 4'd1;
        end else begin
          fmt_seen = 1'b1;
          pos      = '0;
          if (len_acc > FMT_MIN) begin
            remain = len_acc - FMT_MIN;
            ps     = PH_SKIPFMT;
          end else begin
            close_chunk();
          end
        end
      end
      PH_DATA: begin
        r             = '0;
        r.kind        = KIND_SAMPLE;
        r.sample_byte = b;
        r.chunk_start = (remain == len_acc);
        pending_results.push_back(r);
        count_body();
      end
      PH_SKIPFMT, PH_SKIP: count_body();
      PH_PAD: begin
        pad_flag = 1'b0;
        ps       = PH_CHUNKHDR;
        pos      = '0;
      end
      default: ;
    endcase

    // The final byte closes the file with a report and starts over.
    if (eof) begin
      if (ps == PH_HEADER)    set_error(ST_BAD_HDR);
      else if (ps == PH_FMT)  set_error(ST_FMT_TRUNC);
      else if (ps == PH_DATA) set_error(ST_DATA_TRUNC);
      if (err_code != ST_OK) st = err_code;
      else if (!fmt_seen)    st = ST_NO_FMT;
      else if (!have_samples) st = ST_NO_SAMPLES;
      else                   st = ST_OK;
      r        = '0;
      r.kind   = KIND_REPORT;
      if (st == ST_OK) begin
        r.channel_count  = ch_hold;
        r.sample_rate_hz = rate_hold;
        r.sample_bits    = bits_hold;
      end
      r.status = st;
      r.last   = 1'b1;
      pending_results.push_back(r);
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------------------
  // File builders.
  // ---------------------------------------------------------------------------

  task automatic put8(input logic [7:0] b);
    build_q.push_back(b);
  endtask

  task automatic put_hdr(input logic [31:0] tag, input logic [31:0] len);
    for (int i = 3; i >= 0; i--) put8(tag[8*i +: 8]);
    for (int i = 0; i < 4; i++) put8(len[8*i +: 8]);
  endtask

  task automatic put_head();
    put_hdr(RIFF_ID, $urandom);
    for (int i = 3; i >= 0; i--) put8(WAVE_ID[8*i +: 8]);
  endtask

  task automatic put_fmt(input logic [31:0] len, input logic [15:0] ch,
                         input logic [31:0] rate, input logic [15:0] bits);
    put_hdr(TAG_FMT, len);
    for (int i = 0; i < len; i++) begin
      case (i)
        2, 3:       put8(ch[8*(i-2) +: 8]);
        4, 5, 6, 7: put8(rate[8*(i-4) +: 8]);
        14, 15:     put8(bits[8*(i-14) +: 8]);
        default:    put8(8'($urandom));
      endcase
    end
    if (len[0]) put8(8'($urandom));
  endtask

  task automatic put_chunk(input logic [31:0] tag, input logic [31:0] len);
    put_hdr(tag, len);
    repeat (len) put8(8'($urandom));
    if (len[0]) put8(8'($urandom));
  endtask

  // Queue the built file, cut to its first keep bytes when keep is nonzero.
  task automatic ship_file(input int keep, input bit drain);
    file_byte_t fb;
    int         n;
    n = (keep == 0) ? build_q.size() : keep;
    for (int i = 0; i < n; i++) begin
      fb.b     = build_q[i];
      fb.eof   = (i == n - 1);
      fb.drain = drain && (i == 0);
      file_bytes_q.push_back(fb);
    end
    build_q.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Input side: accept at the rising edge, drive at the falling edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      parse_byte(in_byte_value, in_end_of_file);
      bytes_sent++;
    end
  end

  // A change in the accepted count since the last falling edge means the
  // offered item was taken.
  always @(negedge clk) begin
    file_byte_t fb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || bytes_sent != taken_seen) begin
      taken_seen = bytes_sent;
      if (file_bytes_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (file_bytes_q[0].drain && pending_results.size() != 0) begin
        in_valid <= 1'b0;
      end else if (!(bytes_sent >= 800 && bytes_sent < 1100) &&
                   $urandom_range(0, 99) < 35) begin
        in_valid <= 1'b0;
      end else begin
        fb = file_bytes_q.pop_front();
        in_byte_value  <= fb.b;
        in_end_of_file <= fb.eof;
        in_valid       <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall at random, with long holdoffs to fill the block.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if ((holdoffs_done == 0 && results_seen >= 100) ||
                 (holdoffs_done == 1 && results_seen >= 500)) begin
      holdoffs_done++;
      hold_left = HOLDOFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (results_seen >= 250 && results_seen < 450) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 35);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with no expectation waiting");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("sample_byte", 32'(want.sample_byte), 32'(out_sample_byte));
        check_field("chunk_start", 32'(want.chunk_start), 32'(out_chunk_start));
        check_field("channel_count", 32'(want.channel_count), 32'(out_channel_count));
        check_field("sample_rate_hz", want.sample_rate_hz, out_sample_rate_hz);
        check_field("sample_bits", 32'(want.sample_bits), 32'(out_sample_bits));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------

  initial begin
    int          n;
    int          nchunks;
    int          sel;
    int          idx;
    int          keep;
    bit          huge;
    logic [31:0] len_r;

    clear_parser();

    // Clean file, field extremes, final byte on the last sample.
    put_head();
    put_fmt(16, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_hdr(TAG_DATA, 2);
    put8(8'h00);
    put8(8'hFF);
    ship_file(0, 1'b0);

    // File ends inside the header, and on its very first byte.
    put_head();
    ship_file(3, 1'b0);
    put_head();
    ship_file(1, 1'b0);

    // Wrong WAVE byte; everything after it is ignored.
    put_head();
    build_q[9] = build_q[9] ^ 8'h01;
    put_fmt(16, 16'd2, 44100, 16'd16);
    put_chunk(TAG_DATA, 4);
    ship_file(0, 1'b0);

    // fmt chunk shorter than its fixed fields.
    put_head();
    put_chunk(TAG_FMT, 14);
    put_chunk(TAG_DATA, 2);
    ship_file(0, 1'b0);

    // File ends within the fmt fields.
    put_head();
    put_fmt(16, 16'd1, 8000, 16'd8);
    ship_file(25, 1'b0);

    // Huge data chunk cut off after a few samples.
    put_head();
    put_fmt(16, 16'h0000, 32'h0, 16'h0000);
    put_hdr(TAG_DATA, 32'hFFFF_FFFF);
    put8(8'h00);
    put8(8'hFF);
    put8(8'hA5);
    ship_file(0, 1'b0);

    // Samples without any fmt chunk, file ends on the pad byte.
    put_head();
    put_chunk(TAG_DATA, 1);
    ship_file(0, 1'b0);

    // fmt present but only an empty data chunk.
    put_head();
    put_fmt(16, 16'd1, 22050, 16'd16);
    put_chunk(TAG_DATA, 0);
    ship_file(0, 1'b0);

    // Odd unknown chunk, fmt with extra bytes, odd data, a later fmt that
    // overrides, a second data chunk and a partial chunk header at the end.
    put_head();
    put_chunk(TAG_LIST, 3);
    put_fmt(18, 16'd2, 48000, 16'd24);
    put_chunk(TAG_DATA, 5);
    put_fmt(16, 16'd6, 96000, 16'd32);
    put_chunk(TAG_DATA, 4);
    put_hdr(TAG_DATA, 8);
    ship_file(build_q.size() - 4, 1'b1);

    // Nonempty data followed by an empty data chunk.
    put_head();
    put_fmt(16, 16'd1, 11025, 16'd8);
    put_chunk(TAG_DATA, 3);
    put_chunk(TAG_DATA, 0);
    ship_file(0, 1'b0);

    // File ends inside an unknown chunk after a good fmt and data.
    put_head();
    put_fmt(16, 16'd2, 32000, 16'd16);
    put_chunk(TAG_DATA, 2);
    put_chunk(TAG_LIST, 10);
    ship_file(build_q.size() - 5, 1'b0);

    // File ends inside the extra bytes of an fmt chunk.
    put_head();
    put_chunk(TAG_DATA, 2);
    put_fmt(20, 16'd1, 16000, 16'd12);
    ship_file(build_q.size() - 2, 1'b0);

    // Random files: mostly well-formed, some cut short, some noise.
    while (file_bytes_q.size() < TARGET_BYTES) begin
      if ($urandom_range(0, 99) < 8) begin
        n = $urandom_range(1, 16);
        repeat (n) put8(8'($urandom));
      end else begin
        put_head();
        if ($urandom_range(0, 9) == 0) begin
          idx = $urandom_range(0, 7);
          if (idx >= 4) idx += 4;
          build_q[idx] = build_q[idx] ^ 8'($urandom_range(1, 255));
        end
        nchunks = $urandom_range(1, 4);
        huge = 1'b0;
        for (int c = 0; c < nchunks && !huge; c++) begin
          sel = (c == 0 && $urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, 99);
          if (sel < 30) begin
            len_r = ($urandom_range(0, 3) != 0) ? 16 : $urandom_range(17, 23);
            put_fmt(len_r, 16'($urandom), $urandom, 16'($urandom));
          end else if (sel < 70) begin
            len_r = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
            put_chunk(TAG_DATA, len_r);
          end else if (sel < 90) begin
            put_chunk($urandom, $urandom_range(0, 12));
          end else if (sel < 95) begin
            put_chunk(TAG_FMT, $urandom_range(0, 15));
          end else begin
            // Data chunk far longer than the file; it is always cut short.
            put_hdr(TAG_DATA, $urandom | 32'h0000_0100);
            repeat ($urandom_range(1, 6)) put8(8'($urandom));
            huge = 1'b1;
          end
        end
      end
      keep = ($urandom_range(0, 99) < 15) ? $urandom_range(1, build_q.size()) : 0;
      ship_file(keep, $urandom_range(0, 19) == 0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (file_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #(12 * 300000);
    $display("Mismatches found");
    $finish;
  end

endmodule
